// ===== hdl/square_matrix_multiply_unit_defines.svh =====
// Assertion macros shared by the matrix multiply unit.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication
`define SMM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smm_pkg.sv =====
// Types and constants for the matrix multiply unit.
// No dependencies.
package smm_pkg;

    localparam int IDX_W  = 3;   // row / column index
    localparam int DIM_W  = 4;   // dimension register
    localparam int ELEM_W = 16;  // Q8.8 element
    localparam int PROD_W = 32;  // Q16.16 single product
    localparam int VAL_W  = 36;  // Q20.16 accumulator

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // tag that travels with each memory read pair
    typedef struct packed {
        logic             first;  // k == 0
        logic             last;   // k == dim-1
        logic             fin;    // final element of the matrix
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage

// ===== hdl/smm_mem.sv =====
// Synchronous single-port-write, single-port-read memory with registered read data.
// No dependencies.
module smm_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/smm_seq.sv =====
// Read sequencer: walks (row, column, k) and issues paired memory reads.
// Depends on smm_pkg.
module smm_seq #(
    parameter int MAX_DIM = 8,
    parameter int ADDR_W  = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     stall,
    input  logic [smm_pkg::DIM_W-1:0] dim_eff,
    output logic                     idle,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        raddr_a,
    output logic [ADDR_W-1:0]        raddr_b,
    output smm_pkg::tag_t            tag
);
    import smm_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] dm1;
    logic             i_end, j_end, k_end;

    assign dm1   = dim_eff - DIM_W'(1);
    assign i_end = ({1'b0, i_reg} == dm1);
    assign j_end = ({1'b0, j_reg} == dm1);
    assign k_end = ({1'b0, k_reg} == dm1);

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    k_next = k_reg + IDX_W'(1);
                    if (k_end)
                    begin
                        k_next = '0;
                        j_next = j_reg + IDX_W'(1);
                        if (j_end)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                            if (i_end)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        idle  = 1'b0;
        rd_en = 1'b0;
        case (state_reg)
            ST_IDLE: idle  = 1'b1;
            ST_RUN:  rd_en = !stall;
            default: idle  = 1'b0;
        endcase
    end

    assign raddr_a   = ADDR_W'(i_reg * MAX_DIM + k_reg);
    assign raddr_b   = ADDR_W'(k_reg * MAX_DIM + j_reg);
    assign tag.first = (k_reg == '0);
    assign tag.last  = k_end;
    assign tag.fin   = i_end && j_end;
    assign tag.row   = i_reg;
    assign tag.col   = j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== hdl/smm_mac.sv =====
// Multiply-accumulate datapath with the result output register.
// Depends on smm_pkg.
module smm_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  smm_pkg::tag_t                     tag_in,
    input  logic signed [smm_pkg::ELEM_W-1:0] a_data,
    input  logic signed [smm_pkg::ELEM_W-1:0] b_data,
    output logic                              stall,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [smm_pkg::IDX_W-1:0]         out_row,
    output logic [smm_pkg::IDX_W-1:0]         out_column,
    output logic signed [smm_pkg::VAL_W-1:0]  product_value,
    output logic                              last
);
    import smm_pkg::*;

    // stage 1 lines up with memory read data
    logic                     s1_valid_reg, s1_valid_next;
    tag_t                     s1_tag_reg;
    // stage 2 holds the product
    logic                     s2_valid_reg, s2_valid_next;
    tag_t                     s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  acc_reg, acc_next;
    logic signed [VAL_W-1:0]  sum;
    logic                     done;
    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [VAL_W-1:0]  out_val_reg;
    logic                     out_last_reg;

    // element finished but output register still occupied
    assign stall = s2_valid_reg && s2_tag_reg.last && out_valid_reg && !out_ready;
    assign done  = s2_valid_reg && s2_tag_reg.last && !stall;

    assign sum = (s2_tag_reg.first ? VAL_W'(0) : acc_reg)
               + {{(VAL_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        s1_valid_next  = stall ? s1_valid_reg : rd_en;
        s2_valid_next  = stall ? s2_valid_reg : s1_valid_reg;
        acc_next       = (s2_valid_reg && !s2_tag_reg.last) ? sum : acc_reg;
        out_valid_next = done ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= a_data * b_data;
            acc_reg    <= acc_next;
        end
        if (done)
        begin
            out_row_reg  <= s2_tag_reg.row;
            out_col_reg  <= s2_tag_reg.col;
            out_val_reg  <= sum;
            out_last_reg <= s2_tag_reg.fin;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_column    = out_col_reg;
    assign product_value = out_val_reg;
    assign last          = out_last_reg;

endmodule

// ===== hdl/square_matrix_multiply_unit.sv =====
// Results: a compute presents its products one element at a time after the transfer.
// Throughput: one multiply-accumulate per cycle while the output does not stall, set by
// the single read port of each matrix memory; the input stays closed while the sequencer
// issues the reads of a compute, output stalls included.
// Reset: asynchronous, active low; dimension returns to 4, pipeline and output empty,
// matrix memories are not cleared.
module square_matrix_multiply_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: dimension register
    input  logic                              cfg_we,
    input  logic [smm_pkg::DIM_W-1:0]         cfg_data,
    // command input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [smm_pkg::IDX_W-1:0]         row,
    input  logic [smm_pkg::IDX_W-1:0]         column,
    input  logic signed [smm_pkg::ELEM_W-1:0] element,
    // product output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [smm_pkg::IDX_W-1:0]         out_row,
    output logic [smm_pkg::IDX_W-1:0]         out_column,
    output logic signed [smm_pkg::VAL_W-1:0]  product_value,
    output logic                              last
);
    import smm_pkg::*;

`include "square_matrix_multiply_unit_defines.svh"

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DIM_W-1:0]  dim_reg;
    logic [DIM_W-1:0]  dim_eff;
    logic              in_fire;
    logic              in_range;
    logic              we_a, we_b;
    logic              start;
    logic [ADDR_W-1:0] waddr;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [ELEM_W-1:0] rdata_a, rdata_b;
    tag_t              tag;
    logic              stall;
    logic              idle;

    // dimension register; writes must only come while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            dim_reg <= cfg_data;
        end
    end

    // clamp to 1..MAX_DIM
    always_comb
    begin
        if (dim_reg == '0)
        begin
            dim_eff = DIM_W'(1);
        end
        else if (dim_reg > DIM_W'(MAX_DIM))
        begin
            dim_eff = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_eff = dim_reg;
        end
    end

    // Input is taken only while the sequencer is idle, so loads never write
    // an entry while a compute is reading.
    assign in_ready = idle;
    assign in_fire  = in_valid && in_ready;
    assign in_range = ({1'b0, row} < dim_eff) && ({1'b0, column} < dim_eff);
    assign waddr    = ADDR_W'(row * MAX_DIM + column);

    always_comb
    begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        start = 1'b0;
        case (op_t'(opcode))
            OP_LOAD_A:  we_a  = in_fire && in_range;
            OP_LOAD_B:  we_b  = in_fire && in_range;
            OP_COMPUTE: start = in_fire;
            default:    start = 1'b0;  // unused opcode: transfer is dropped
        endcase
    end

    smm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_mem_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (element),
        .re    (rd_en),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    smm_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_mem_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (element),
        .re    (rd_en),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    smm_seq #(
        .MAX_DIM (MAX_DIM),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .stall   (stall),
        .dim_eff (dim_eff),
        .idle    (idle),
        .rd_en   (rd_en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .tag     (tag)
    );

    // The whole read/multiply/accumulate pipe freezes while a finished
    // element waits for the output register.
    smm_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_en         (rd_en),
        .tag_in        (tag),
        .a_data        (rdata_a),
        .b_data        (rdata_b),
        .stall         (stall),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_column    (out_column),
        .product_value (product_value),
        .last          (last)
    );

    `SMM_ASSERT_NOW(a_no_rw_overlap, we_a || we_b, !rd_en, "load write during compute read")
    `SMM_ASSERT_NOW(a_last_on_diag, out_valid && last, out_row == out_column, "last off diagonal")
    `SMM_ASSERT_NEXT(a_busy_after_start, start, !in_ready, "input open right after compute")

endmodule
